// ----- rtl/i2c_register_transaction_sequencer_macros.svh -----
// ---------------------------------------------------------------------------
// i2c register transaction sequencer assertion macros
// shared concurrent assertion forms for the sequencer checker
// ---------------------------------------------------------------------------
`ifndef I2C_REGISTER_TRANSACTION_SEQUENCER_MACROS_SVH
`define I2C_REGISTER_TRANSACTION_SEQUENCER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define RTS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2c sequencer check failed");

// next-cycle implication, disabled while in reset
`define RTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2c sequencer check failed");

`endif

// ----- rtl/i2c_rts_pkg.sv -----
// ---------------------------------------------------------------------------
// i2c register transaction sequencer package
// codes, status values and request/result types shared by the sequencer
// ---------------------------------------------------------------------------
package i2c_rts_pkg;

    localparam int MAX_BURST = 256;
    localparam int LEFT_RAW  = $clog2(MAX_BURST + 1);
    localparam int LEFT_W    = (LEFT_RAW < 2) ? 2 : LEFT_RAW;

    // transaction codes
    localparam logic [2:0] OP_PROBE   = 3'd0;
    localparam logic [2:0] OP_WRITE8  = 3'd1;
    localparam logic [2:0] OP_BURST   = 3'd2;
    localparam logic [2:0] OP_WRITE16 = 3'd3;
    localparam logic [2:0] OP_READ16  = 3'd4;

    // request kinds
    localparam logic CMD_BEGIN  = 1'b0;
    localparam logic CMD_STATUS = 1'b1;

    // core status codes
    localparam logic [7:0] STS_BUS_ERR      = 8'h00;
    localparam logic [7:0] STS_START        = 8'h08;
    localparam logic [7:0] STS_RSTART       = 8'h10;
    localparam logic [7:0] STS_SLAW_ACK     = 8'h18;
    localparam logic [7:0] STS_SLAW_NACK    = 8'h20;
    localparam logic [7:0] STS_TXDATA_ACK   = 8'h28;
    localparam logic [7:0] STS_TXDATA_NACK  = 8'h30;
    localparam logic [7:0] STS_SLAR_ACK     = 8'h40;
    localparam logic [7:0] STS_SLAR_NACK    = 8'h48;
    localparam logic [7:0] STS_RXDATA_ACK   = 8'h50;
    localparam logic [7:0] STS_RXDATA_NACK  = 8'h58;

    localparam logic [7:0] READ_BIT = 8'h01;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_START  = 4'd1,
        PH_SLA    = 4'd2,
        PH_AHI    = 4'd3,
        PH_ALO    = 4'd4,
        PH_DHI    = 4'd5,
        PH_DLO    = 4'd6,
        PH_RSTART = 4'd7,
        PH_RSLA   = 4'd8,
        PH_RMORE  = 4'd9,
        PH_RLAST  = 4'd10
    } t_phase;

    typedef enum logic [2:0] {
        ACT_NONE     = 3'd0,
        ACT_START    = 3'd1,
        ACT_SI       = 3'd2,
        ACT_START_SI = 3'd3,
        ACT_SI_ACK   = 3'd4,
        ACT_STOP_SI  = 3'd5,
        ACT_TO_STOP  = 3'd6
    } t_action;

    typedef struct packed {
        logic        cmd;
        logic [2:0]  op;
        logic [7:0]  dev_addr;
        logic [15:0] sub_addr;
        logic [15:0] wdata;
        logic [8:0]  burst_len;
        logic [7:0]  core_status;
        logic        core_timeout;
        logic [7:0]  core_rx_byte;
    } t_item;

    typedef struct packed {
        t_action    action;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       rx_last;
        logic       done_res;
        logic       ok;
        logic       busy_res;
    } t_result;

    typedef struct packed {
        t_phase            phase;
        logic [2:0]        active_op;
        logic [7:0]        device_byte;
        logic [15:0]       register_address;
        logic [15:0]       write_value;
        logic [LEFT_W-1:0] bytes_left;
    } t_ctx;

    // status code each phase waits for
    function automatic logic [7:0] wait_code(input t_phase ph);
        logic [7:0] code;
        case (ph)
            PH_START:  code = STS_START;
            PH_SLA:    code = STS_SLAW_ACK;
            PH_AHI:    code = STS_TXDATA_ACK;
            PH_ALO:    code = STS_TXDATA_ACK;
            PH_DHI:    code = STS_TXDATA_ACK;
            PH_DLO:    code = STS_TXDATA_ACK;
            PH_RSTART: code = STS_RSTART;
            PH_RSLA:   code = STS_SLAR_ACK;
            PH_RMORE:  code = STS_RXDATA_ACK;
            PH_RLAST:  code = STS_RXDATA_NACK;
            default:   code = STS_BUS_ERR;
        endcase
        return code;
    endfunction

endpackage

// ----- rtl/i2c_register_transaction_sequencer.sv -----
// ---------------------------------------------------------------------------
// i2c register transaction sequencer
// answers begin requests and core status reports with the next i2c action
// ---------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  request   in         i_in_valid / o_in_ready   i_cmd .. i_core_rx_byte
//  result    out        o_out_valid / i_out_ready o_action .. o_busy_res
//
//  one request per cycle sustained while results are not stalled; a request passes the
//  request register, then the result register after the step logic
//  the transaction state only advances when a request moves into the result register
//  i_rst_n low (synchronous) empties both registers and returns the state to idle
//  a stalled result holds; the request register keeps taking a new request behind it
//  until it too is full
// ---------------------------------------------------------------------------
module i2c_register_transaction_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_cmd,
    input  logic [2:0]  i_op,
    input  logic [7:0]  i_dev_addr,
    input  logic [15:0] i_sub_addr,
    input  logic [15:0] i_wdata,
    input  logic [8:0]  i_burst_len,
    input  logic [7:0]  i_core_status,
    input  logic        i_core_timeout,
    input  logic [7:0]  i_core_rx_byte,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_action,
    output logic        o_tx_valid,
    output logic [7:0]  o_tx_byte,
    output logic        o_rx_valid,
    output logic [7:0]  o_rx_byte,
    output logic        o_rx_last,
    output logic        o_done_res,
    output logic        o_ok,
    output logic        o_busy_res
);

    // request register
    logic                 r_in_valid;
    i2c_rts_pkg::t_item   r_item;
    i2c_rts_pkg::t_item   n_item;

    // transaction state
    i2c_rts_pkg::t_ctx    r_ctx;
    i2c_rts_pkg::t_ctx    n_ctx;

    // result register
    logic                 r_out_valid;
    i2c_rts_pkg::t_result r_res;
    i2c_rts_pkg::t_result n_res;

    logic step_fire;   // request register moves into the result register
    logic in_fire;

    assign step_fire  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || step_fire;
    assign in_fire    = i_in_valid && o_in_ready;

    // pack the request ports
    always_comb begin
        n_item.cmd          = i_cmd;
        n_item.op           = i_op;
        n_item.dev_addr     = i_dev_addr;
        n_item.sub_addr     = i_sub_addr;
        n_item.wdata        = i_wdata;
        n_item.burst_len    = i_burst_len;
        n_item.core_status  = i_core_status;
        n_item.core_timeout = i_core_timeout;
        n_item.core_rx_byte = i_core_rx_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (step_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    // payload only, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_item <= n_item;
        end
    end

    // sequencer step: phase decode, byte select, read countdown
    i2c_rts_step u_step (
        .i_item (r_item),
        .i_ctx  (r_ctx),
        .o_res  (n_res),
        .o_ctx  (n_ctx)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx.phase            <= i2c_rts_pkg::PH_IDLE;
            r_ctx.active_op        <= '0;
            r_ctx.device_byte      <= '0;
            r_ctx.register_address <= '0;
            r_ctx.write_value      <= '0;
            r_ctx.bytes_left       <= '0;
        end else if (step_fire) begin
            r_ctx <= n_ctx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_fire) begin
            r_res <= n_res;
        end
    end

    // result ports
    assign o_out_valid = r_out_valid;
    assign o_action    = r_res.action;
    assign o_tx_valid  = r_res.tx_valid;
    assign o_tx_byte   = r_res.tx_byte;
    assign o_rx_valid  = r_res.rx_valid;
    assign o_rx_byte   = r_res.rx_byte;
    assign o_rx_last   = r_res.rx_last;
    assign o_done_res  = r_res.done_res;
    assign o_ok        = r_res.ok;
    assign o_busy_res  = r_res.busy_res;

endmodule

// ----- rtl/i2c_rts_step.sv -----
// ---------------------------------------------------------------------------
// i2c rts step
// next-state and result logic for one request against the sequencer state
// ---------------------------------------------------------------------------
module i2c_rts_step (
    input  i2c_rts_pkg::t_item   i_item,
    input  i2c_rts_pkg::t_ctx    i_ctx,
    output i2c_rts_pkg::t_result o_res,
    output i2c_rts_pkg::t_ctx    o_ctx
);

    logic                           wide;
    logic                           fail_status;
    logic [i2c_rts_pkg::LEFT_W-1:0] left_dec;

    assign wide = i_ctx.active_op inside {i2c_rts_pkg::OP_WRITE16, i2c_rts_pkg::OP_READ16};

    assign fail_status = i_item.core_status inside {i2c_rts_pkg::STS_SLAW_NACK,
                                                    i2c_rts_pkg::STS_BUS_ERR,
                                                    i2c_rts_pkg::STS_TXDATA_NACK,
                                                    i2c_rts_pkg::STS_SLAR_NACK};

    // saturating count-down of remaining read bytes
    assign left_dec = (i_ctx.bytes_left != '0) ? i_ctx.bytes_left - 1'b1 : i_ctx.bytes_left;

    always_comb begin
        o_ctx = i_ctx;
        o_res = '0;
        o_res.action = i2c_rts_pkg::ACT_NONE;
        if (i_item.cmd == i2c_rts_pkg::CMD_BEGIN) begin
            if (i_ctx.phase == i2c_rts_pkg::PH_IDLE) begin
                if (i_item.op > i2c_rts_pkg::OP_READ16) begin
                    o_res.done_res = 1'b1;
                end else if (i_item.op == i2c_rts_pkg::OP_BURST &&
                             (i_item.burst_len == '0 ||
                              32'(i_item.burst_len) > 32'(i2c_rts_pkg::MAX_BURST))) begin
                    o_res.done_res = 1'b1;
                end else begin
                    o_ctx.active_op        = i_item.op;
                    o_ctx.device_byte      = i_item.dev_addr;
                    o_ctx.register_address = i_item.sub_addr;
                    o_ctx.write_value      = i_item.wdata;
                    if (i_item.op == i2c_rts_pkg::OP_BURST) begin
                        o_ctx.bytes_left = i2c_rts_pkg::LEFT_W'(i_item.burst_len);
                    end else if (i_item.op == i2c_rts_pkg::OP_READ16) begin
                        o_ctx.bytes_left = i2c_rts_pkg::LEFT_W'(2);
                    end else begin
                        o_ctx.bytes_left = '0;
                    end
                    o_res.action = i2c_rts_pkg::ACT_START;
                    o_ctx.phase  = i2c_rts_pkg::PH_START;
                end
            end
        end else if (i_ctx.phase != i2c_rts_pkg::PH_IDLE) begin
            if (i_item.core_status != i2c_rts_pkg::wait_code(i_ctx.phase)) begin
                if (i_item.core_timeout) begin
                    o_res.action   = i2c_rts_pkg::ACT_TO_STOP;
                    o_res.done_res = 1'b1;
                    o_ctx.phase    = i2c_rts_pkg::PH_IDLE;
                end else if (fail_status) begin
                    o_res.action   = i2c_rts_pkg::ACT_STOP_SI;
                    o_res.done_res = 1'b1;
                    o_ctx.phase    = i2c_rts_pkg::PH_IDLE;
                end
            end else begin
                case (i_ctx.phase)
                    i2c_rts_pkg::PH_START: begin
                        o_res.action   = i2c_rts_pkg::ACT_SI;
                        o_res.tx_valid = 1'b1;
                        o_res.tx_byte  = i_ctx.device_byte;
                        o_ctx.phase    = i2c_rts_pkg::PH_SLA;
                    end
                    i2c_rts_pkg::PH_SLA: begin
                        if (i_ctx.active_op == i2c_rts_pkg::OP_PROBE) begin
                            o_res.action   = i2c_rts_pkg::ACT_STOP_SI;
                            o_res.done_res = 1'b1;
                            o_res.ok       = 1'b1;
                            o_ctx.phase    = i2c_rts_pkg::PH_IDLE;
                        end else if (wide) begin
                            o_res.action   = i2c_rts_pkg::ACT_SI;
                            o_res.tx_valid = 1'b1;
                            o_res.tx_byte  = i_ctx.register_address[15:8];
                            o_ctx.phase    = i2c_rts_pkg::PH_AHI;
                        end else begin
                            o_res.action   = i2c_rts_pkg::ACT_SI;
                            o_res.tx_valid = 1'b1;
                            o_res.tx_byte  = i_ctx.register_address[7:0];
                            o_ctx.phase    = i2c_rts_pkg::PH_ALO;
                        end
                    end
                    i2c_rts_pkg::PH_AHI: begin
                        o_res.action   = i2c_rts_pkg::ACT_SI;
                        o_res.tx_valid = 1'b1;
                        o_res.tx_byte  = i_ctx.register_address[7:0];
                        o_ctx.phase    = i2c_rts_pkg::PH_ALO;
                    end
                    i2c_rts_pkg::PH_ALO: begin
                        if (i_ctx.active_op == i2c_rts_pkg::OP_WRITE8) begin
                            o_res.action   = i2c_rts_pkg::ACT_SI;
                            o_res.tx_valid = 1'b1;
                            o_res.tx_byte  = i_ctx.write_value[7:0];
                            o_ctx.phase    = i2c_rts_pkg::PH_DLO;
                        end else if (i_ctx.active_op == i2c_rts_pkg::OP_WRITE16) begin
                            o_res.action   = i2c_rts_pkg::ACT_SI;
                            o_res.tx_valid = 1'b1;
                            o_res.tx_byte  = i_ctx.write_value[15:8];
                            o_ctx.phase    = i2c_rts_pkg::PH_DHI;
                        end else begin
                            o_res.action = i2c_rts_pkg::ACT_START_SI;
                            o_ctx.phase  = i2c_rts_pkg::PH_RSTART;
                        end
                    end
                    i2c_rts_pkg::PH_DHI: begin
                        o_res.action   = i2c_rts_pkg::ACT_SI;
                        o_res.tx_valid = 1'b1;
                        o_res.tx_byte  = i_ctx.write_value[7:0];
                        o_ctx.phase    = i2c_rts_pkg::PH_DLO;
                    end
                    i2c_rts_pkg::PH_DLO: begin
                        o_res.action   = i2c_rts_pkg::ACT_STOP_SI;
                        o_res.done_res = 1'b1;
                        o_res.ok       = 1'b1;
                        o_ctx.phase    = i2c_rts_pkg::PH_IDLE;
                    end
                    i2c_rts_pkg::PH_RSTART: begin
                        o_res.action   = i2c_rts_pkg::ACT_SI;
                        o_res.tx_valid = 1'b1;
                        o_res.tx_byte  = i_ctx.device_byte | i2c_rts_pkg::READ_BIT;
                        o_ctx.phase    = i2c_rts_pkg::PH_RSLA;
                    end
                    i2c_rts_pkg::PH_RSLA: begin
                        if (i_ctx.bytes_left > i2c_rts_pkg::LEFT_W'(1)) begin
                            o_res.action = i2c_rts_pkg::ACT_SI_ACK;
                            o_ctx.phase  = i2c_rts_pkg::PH_RMORE;
                        end else begin
                            o_res.action = i2c_rts_pkg::ACT_SI;
                            o_ctx.phase  = i2c_rts_pkg::PH_RLAST;
                        end
                    end
                    i2c_rts_pkg::PH_RMORE: begin
                        o_res.rx_valid   = 1'b1;
                        o_res.rx_byte    = i_item.core_rx_byte;
                        o_ctx.bytes_left = left_dec;
                        if (left_dec > i2c_rts_pkg::LEFT_W'(1)) begin
                            o_res.action = i2c_rts_pkg::ACT_SI_ACK;
                            o_ctx.phase  = i2c_rts_pkg::PH_RMORE;
                        end else begin
                            o_res.action = i2c_rts_pkg::ACT_SI;
                            o_ctx.phase  = i2c_rts_pkg::PH_RLAST;
                        end
                    end
                    i2c_rts_pkg::PH_RLAST: begin
                        o_res.rx_valid   = 1'b1;
                        o_res.rx_byte    = i_item.core_rx_byte;
                        o_res.rx_last    = 1'b1;
                        o_ctx.bytes_left = '0;
                        o_res.action     = i2c_rts_pkg::ACT_STOP_SI;
                        o_res.done_res   = 1'b1;
                        o_res.ok         = 1'b1;
                        o_ctx.phase      = i2c_rts_pkg::PH_IDLE;
                    end
                    default: begin
                        o_ctx.phase = i2c_rts_pkg::PH_IDLE;
                    end
                endcase
            end
        end
        o_res.busy_res = (o_ctx.phase != i2c_rts_pkg::PH_IDLE);
    end

endmodule

// ----- rtl/i2c_rts_checker.sv -----
// ---------------------------------------------------------------------------
// i2c rts checker
// port-level checks on the sequencer results, bound to the top level
// ---------------------------------------------------------------------------
`include "i2c_register_transaction_sequencer_macros.svh"

module i2c_rts_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        i_cmd,
    input logic [2:0]  i_op,
    input logic [7:0]  i_dev_addr,
    input logic [15:0] i_sub_addr,
    input logic [15:0] i_wdata,
    input logic [8:0]  i_burst_len,
    input logic [7:0]  i_core_status,
    input logic        i_core_timeout,
    input logic [7:0]  i_core_rx_byte,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  o_action,
    input logic        o_tx_valid,
    input logic [7:0]  o_tx_byte,
    input logic        o_rx_valid,
    input logic [7:0]  o_rx_byte,
    input logic        o_rx_last,
    input logic        o_done_res,
    input logic        o_ok,
    input logic        o_busy_res
);

    // a finished transaction leaves the sequencer idle
    `RTS_ASSERT_SAME(a_done_not_busy, i_clk, i_rst_n, o_out_valid && o_done_res, !o_busy_res)

    // the last read byte closes the transaction successfully
    `RTS_ASSERT_SAME(a_last_closes, i_clk, i_rst_n, o_out_valid && o_rx_last,
                     o_rx_valid && o_done_res && o_ok && (o_action == i2c_rts_pkg::ACT_STOP_SI))

    // a byte to transmit always goes with a plain interrupt clear
    `RTS_ASSERT_SAME(a_tx_with_si, i_clk, i_rst_n, o_out_valid && o_tx_valid,
                     o_action == i2c_rts_pkg::ACT_SI)

    // a stalled result holds
    `RTS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
                     o_out_valid && $stable(o_action) && $stable(o_busy_res))

endmodule

bind i2c_register_transaction_sequencer i2c_rts_checker u_rts_checker (.*);

// ----- bench/i2c_register_transaction_sequencer_test.sv -----
// ---------------------------------------------------------------------------
// i2c register transaction sequencer test
// drives begin requests and core status reports through the request channel,
// predicts every answer from a local copy of the sequencer state, and checks
// each result field by field under random sender gaps and receiver stalls
// ---------------------------------------------------------------------------
module i2c_register_transaction_sequencer_test;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #5 i_clk = ~i_clk;

    // request channel, all known from time zero
    logic        i_in_valid     = 1'b0;
    logic        i_cmd          = 1'b0;
    logic [2:0]  i_op           = 3'd0;
    logic [7:0]  i_dev_addr     = 8'd0;
    logic [15:0] i_sub_addr     = 16'd0;
    logic [15:0] i_wdata        = 16'd0;
    logic [8:0]  i_burst_len    = 9'd0;
    logic [7:0]  i_core_status  = 8'd0;
    logic        i_core_timeout = 1'b0;
    logic [7:0]  i_core_rx_byte = 8'd0;
    logic        o_in_ready;

    // result channel
    logic        i_out_ready = 1'b0;
    logic        o_out_valid;
    logic [2:0]  o_action;
    logic        o_tx_valid;
    logic [7:0]  o_tx_byte;
    logic        o_rx_valid;
    logic [7:0]  o_rx_byte;
    logic        o_rx_last;
    logic        o_done_res;
    logic        o_ok;
    logic        o_busy_res;

    i2c_register_transaction_sequencer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_cmd          (i_cmd),
        .i_op           (i_op),
        .i_dev_addr     (i_dev_addr),
        .i_sub_addr     (i_sub_addr),
        .i_wdata        (i_wdata),
        .i_burst_len    (i_burst_len),
        .i_core_status  (i_core_status),
        .i_core_timeout (i_core_timeout),
        .i_core_rx_byte (i_core_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_action       (o_action),
        .o_tx_valid     (o_tx_valid),
        .o_tx_byte      (o_tx_byte),
        .o_rx_valid     (o_rx_valid),
        .o_rx_byte      (o_rx_byte),
        .o_rx_last      (o_rx_last),
        .o_done_res     (o_done_res),
        .o_ok           (o_ok),
        .o_busy_res     (o_busy_res)
    );

    // answers predicted at request accept, oldest first
    i2c_rts_pkg::t_result answers_due[$];
    int unsigned mismatch_count = 0;
    int unsigned requests_sent  = 0;
    int unsigned burst_left     = 5;

    // local copy of the sequencer state
    i2c_rts_pkg::t_phase            seq_phase      = i2c_rts_pkg::PH_IDLE;
    logic [2:0]                     seq_op         = 3'd0;
    logic [7:0]                     seq_device     = 8'd0;
    logic [15:0]                    seq_register   = 16'd0;
    logic [15:0]                    seq_wvalue     = 16'd0;
    logic [i2c_rts_pkg::LEFT_W-1:0] seq_bytes_left = '0;

    // statuses that abort a transaction with stop when not awaited
    function automatic logic is_bus_failure(input logic [7:0] sts);
        return sts inside {i2c_rts_pkg::STS_BUS_ERR, i2c_rts_pkg::STS_SLAW_NACK,
                           i2c_rts_pkg::STS_TXDATA_NACK, i2c_rts_pkg::STS_SLAR_NACK};
    endfunction

    // next answer of the sequencer for one request, advances the local state
    function automatic i2c_rts_pkg::t_result sequencer_answer(input i2c_rts_pkg::t_item rq);
        i2c_rts_pkg::t_result r;
        logic [7:0]           awaited;
        logic                 wide;
        r = '0;
        awaited = i2c_rts_pkg::STS_BUS_ERR;
        wide = (seq_op == i2c_rts_pkg::OP_WRITE16) || (seq_op == i2c_rts_pkg::OP_READ16);
        if (rq.cmd == i2c_rts_pkg::CMD_BEGIN) begin
            // a begin while busy is dropped without effect
            if (seq_phase == i2c_rts_pkg::PH_IDLE) begin
                if (rq.op > i2c_rts_pkg::OP_READ16 || (rq.op == i2c_rts_pkg::OP_BURST &&
                    (rq.burst_len == 9'd0 || rq.burst_len > i2c_rts_pkg::MAX_BURST))) begin
                    // refused at once, nothing goes on the bus
                    r.done_res = 1'b1;
                end else begin
                    seq_op       = rq.op;
                    seq_device   = rq.dev_addr;
                    seq_register = rq.sub_addr;
                    seq_wvalue   = rq.wdata;
                    if (rq.op == i2c_rts_pkg::OP_BURST)
                        seq_bytes_left = rq.burst_len;
                    else if (rq.op == i2c_rts_pkg::OP_READ16)
                        seq_bytes_left = i2c_rts_pkg::LEFT_W'(2);
                    else
                        seq_bytes_left = '0;
                    r.action  = i2c_rts_pkg::ACT_START;
                    seq_phase = i2c_rts_pkg::PH_START;
                end
            end
        end else if (seq_phase != i2c_rts_pkg::PH_IDLE) begin
            case (seq_phase)
                i2c_rts_pkg::PH_START:  awaited = i2c_rts_pkg::STS_START;
                i2c_rts_pkg::PH_SLA:    awaited = i2c_rts_pkg::STS_SLAW_ACK;
                i2c_rts_pkg::PH_RSTART: awaited = i2c_rts_pkg::STS_RSTART;
                i2c_rts_pkg::PH_RSLA:   awaited = i2c_rts_pkg::STS_SLAR_ACK;
                i2c_rts_pkg::PH_RMORE:  awaited = i2c_rts_pkg::STS_RXDATA_ACK;
                i2c_rts_pkg::PH_RLAST:  awaited = i2c_rts_pkg::STS_RXDATA_NACK;
                default:                awaited = i2c_rts_pkg::STS_TXDATA_ACK;
            endcase
            if (rq.core_status != awaited) begin
                // timeout wins over a failure status, anything else is ignored
                if (rq.core_timeout) begin
                    r.action   = i2c_rts_pkg::ACT_TO_STOP;
                    r.done_res = 1'b1;
                    seq_phase  = i2c_rts_pkg::PH_IDLE;
                end else if (is_bus_failure(rq.core_status)) begin
                    r.action   = i2c_rts_pkg::ACT_STOP_SI;
                    r.done_res = 1'b1;
                    seq_phase  = i2c_rts_pkg::PH_IDLE;
                end
            end else begin
                case (seq_phase)
                    i2c_rts_pkg::PH_START: begin
                        r.action   = i2c_rts_pkg::ACT_SI;
                        r.tx_valid = 1'b1;
                        r.tx_byte  = seq_device;
                        seq_phase  = i2c_rts_pkg::PH_SLA;
                    end
                    i2c_rts_pkg::PH_SLA: begin
                        if (seq_op == i2c_rts_pkg::OP_PROBE) begin
                            r.action   = i2c_rts_pkg::ACT_STOP_SI;
                            r.done_res = 1'b1;
                            r.ok       = 1'b1;
                            seq_phase  = i2c_rts_pkg::PH_IDLE;
                        end else begin
                            r.action   = i2c_rts_pkg::ACT_SI;
                            r.tx_valid = 1'b1;
                            r.tx_byte  = wide ? seq_register[15:8] : seq_register[7:0];
                            seq_phase  = wide ? i2c_rts_pkg::PH_AHI : i2c_rts_pkg::PH_ALO;
                        end
                    end
                    i2c_rts_pkg::PH_AHI: begin
                        r.action   = i2c_rts_pkg::ACT_SI;
                        r.tx_valid = 1'b1;
                        r.tx_byte  = seq_register[7:0];
                        seq_phase  = i2c_rts_pkg::PH_ALO;
                    end
                    i2c_rts_pkg::PH_ALO: begin
                        if (seq_op == i2c_rts_pkg::OP_WRITE8) begin
                            r.action   = i2c_rts_pkg::ACT_SI;
                            r.tx_valid = 1'b1;
                            r.tx_byte  = seq_wvalue[7:0];
                            seq_phase  = i2c_rts_pkg::PH_DLO;
                        end else if (seq_op == i2c_rts_pkg::OP_WRITE16) begin
                            r.action   = i2c_rts_pkg::ACT_SI;
                            r.tx_valid = 1'b1;
                            r.tx_byte  = seq_wvalue[15:8];
                            seq_phase  = i2c_rts_pkg::PH_DHI;
                        end else begin
                            // reads turn the bus around with a repeated start
                            r.action  = i2c_rts_pkg::ACT_START_SI;
                            seq_phase = i2c_rts_pkg::PH_RSTART;
                        end
                    end
                    i2c_rts_pkg::PH_DHI: begin
                        r.action   = i2c_rts_pkg::ACT_SI;
                        r.tx_valid = 1'b1;
                        r.tx_byte  = seq_wvalue[7:0];
                        seq_phase  = i2c_rts_pkg::PH_DLO;
                    end
                    i2c_rts_pkg::PH_DLO: begin
                        r.action   = i2c_rts_pkg::ACT_STOP_SI;
                        r.done_res = 1'b1;
                        r.ok       = 1'b1;
                        seq_phase  = i2c_rts_pkg::PH_IDLE;
                    end
                    i2c_rts_pkg::PH_RSTART: begin
                        r.action   = i2c_rts_pkg::ACT_SI;
                        r.tx_valid = 1'b1;
                        r.tx_byte  = seq_device | i2c_rts_pkg::READ_BIT;
                        seq_phase  = i2c_rts_pkg::PH_RSLA;
                    end
                    i2c_rts_pkg::PH_RSLA, i2c_rts_pkg::PH_RMORE: begin
                        if (seq_phase == i2c_rts_pkg::PH_RMORE) begin
                            r.rx_valid = 1'b1;
                            r.rx_byte  = rq.core_rx_byte;
                            if (seq_bytes_left != '0)
                                seq_bytes_left = seq_bytes_left - 1'b1;
                        end
                        // ack while more than one byte remains, nack the last
                        if (seq_bytes_left > 1) begin
                            r.action  = i2c_rts_pkg::ACT_SI_ACK;
                            seq_phase = i2c_rts_pkg::PH_RMORE;
                        end else begin
                            r.action  = i2c_rts_pkg::ACT_SI;
                            seq_phase = i2c_rts_pkg::PH_RLAST;
                        end
                    end
                    i2c_rts_pkg::PH_RLAST: begin
                        r.rx_valid     = 1'b1;
                        r.rx_byte      = rq.core_rx_byte;
                        r.rx_last      = 1'b1;
                        seq_bytes_left = '0;
                        r.action       = i2c_rts_pkg::ACT_STOP_SI;
                        r.done_res     = 1'b1;
                        r.ok           = 1'b1;
                        seq_phase      = i2c_rts_pkg::PH_IDLE;
                    end
                    default: seq_phase = i2c_rts_pkg::PH_IDLE;
                endcase
            end
        end
        r.busy_res = (seq_phase != i2c_rts_pkg::PH_IDLE);
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    // result check and request capture, both on the sampled edge values
    always @(posedge i_clk) begin : scoreboard
        i2c_rts_pkg::t_result want;
        i2c_rts_pkg::t_item   seen;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (answers_due.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result expected none actual action %0h",
                             $time, o_action);
                end else begin
                    want = answers_due.pop_front();
                    compare_field("action", 8'(want.action), 8'(o_action));
                    compare_field("tx_valid", 8'(want.tx_valid), 8'(o_tx_valid));
                    compare_field("tx_byte", want.tx_byte, o_tx_byte);
                    compare_field("rx_valid", 8'(want.rx_valid), 8'(o_rx_valid));
                    compare_field("rx_byte", want.rx_byte, o_rx_byte);
                    compare_field("rx_last", 8'(want.rx_last), 8'(o_rx_last));
                    compare_field("done_res", 8'(want.done_res), 8'(o_done_res));
                    compare_field("ok", 8'(want.ok), 8'(o_ok));
                    compare_field("busy_res", 8'(want.busy_res), 8'(o_busy_res));
                end
            end
            if (i_in_valid && o_in_ready) begin
                seen.cmd          = i_cmd;
                seen.op           = i_op;
                seen.dev_addr     = i_dev_addr;
                seen.sub_addr     = i_sub_addr;
                seen.wdata        = i_wdata;
                seen.burst_len    = i_burst_len;
                seen.core_status  = i_core_status;
                seen.core_timeout = i_core_timeout;
                seen.core_rx_byte = i_core_rx_byte;
                answers_due.push_back(sequencer_answer(seen));
            end
        end
    end

    // receiver: always ready, mostly ready, mostly stalled, fixed long stalls
    int unsigned sink_cycle = 0;

    always @(posedge i_clk) begin
        sink_cycle <= sink_cycle + 1;
        case ((sink_cycle / 300) % 4)
            0:       i_out_ready <= 1'b1;
            1:       i_out_ready <= ($urandom_range(0, 3) != 0);
            2:       i_out_ready <= ($urandom_range(0, 3) == 0);
            default: i_out_ready <= ((sink_cycle % 16) >= 11);
        endcase
    end

    // one request, held until accepted; bursts end in a random gap
    task automatic send_request(input i2c_rts_pkg::t_item rq);
        i_in_valid     <= 1'b1;
        i_cmd          <= rq.cmd;
        i_op           <= rq.op;
        i_dev_addr     <= rq.dev_addr;
        i_sub_addr     <= rq.sub_addr;
        i_wdata        <= rq.wdata;
        i_burst_len    <= rq.burst_len;
        i_core_status  <= rq.core_status;
        i_core_timeout <= rq.core_timeout;
        i_core_rx_byte <= rq.core_rx_byte;
        do @(posedge i_clk); while (!o_in_ready);
        requests_sent++;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
    endtask

    // sender holds off until every answer is back
    task automatic wait_until_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (answers_due.size() != 0);
    endtask

    // request with every field random
    function automatic i2c_rts_pkg::t_item random_request();
        i2c_rts_pkg::t_item rq;
        rq.cmd          = 1'($urandom_range(0, 1));
        rq.op           = 3'($urandom_range(0, 7));
        rq.dev_addr     = 8'($urandom_range(0, 255));
        rq.sub_addr     = 16'($urandom_range(0, 65535));
        rq.wdata        = 16'($urandom_range(0, 65535));
        rq.burst_len    = 9'($urandom_range(0, 511));
        rq.core_status  = 8'($urandom_range(0, 255));
        rq.core_timeout = 1'($urandom_range(0, 1));
        rq.core_rx_byte = 8'($urandom_range(0, 255));
        return rq;
    endfunction

    function automatic i2c_rts_pkg::t_item begin_request(input logic [2:0] op,
                                                         input logic [7:0] slave,
                                                         input logic [15:0] regad,
                                                         input logic [15:0] wdat,
                                                         input logic [8:0] len);
        i2c_rts_pkg::t_item rq;
        rq           = random_request();
        rq.cmd       = i2c_rts_pkg::CMD_BEGIN;
        rq.op        = op;
        rq.dev_addr  = slave;
        rq.sub_addr  = regad;
        rq.wdata     = wdat;
        rq.burst_len = len;
        return rq;
    endfunction

    function automatic i2c_rts_pkg::t_item status_report(input logic [7:0] sts,
                                                         input logic tmo);
        i2c_rts_pkg::t_item rq;
        rq              = random_request();
        rq.cmd          = i2c_rts_pkg::CMD_STATUS;
        rq.core_status  = sts;
        rq.core_timeout = tmo;
        return rq;
    endfunction

    // a status the sequencer neither awaits nor treats as failure
    function automatic logic [7:0] ignored_status(input logic [7:0] awaited);
        logic [7:0] sts;
        sts = 8'($urandom_range(0, 255));
        while (sts == awaited || is_bus_failure(sts))
            sts = 8'($urandom_range(0, 255));
        return sts;
    endfunction

    // begin that is refused: unknown op or burst length out of range
    function automatic i2c_rts_pkg::t_item refused_begin();
        i2c_rts_pkg::t_item rq;
        rq = random_request();
        rq.cmd = i2c_rts_pkg::CMD_BEGIN;
        if ($urandom_range(0, 1)) begin
            rq.op = 3'($urandom_range(5, 7));
        end else begin
            rq.op        = i2c_rts_pkg::OP_BURST;
            rq.burst_len = $urandom_range(0, 1) ? 9'd0
                         : 9'($urandom_range(i2c_rts_pkg::MAX_BURST + 1, 511));
        end
        return rq;
    endfunction

    // one well-formed transaction with optional noise and an optional abort
    task automatic run_transaction(input i2c_rts_pkg::t_item start,
                                   input int unsigned noise_pct,
                                   input int unsigned abort_pct);
        logic [7:0]         script[$];
        logic [7:0]         awaited;
        logic [7:0]         sts;
        i2c_rts_pkg::t_item rq;
        int unsigned        n;
        script.push_back(i2c_rts_pkg::STS_START);
        script.push_back(i2c_rts_pkg::STS_SLAW_ACK);
        case (start.op)
            i2c_rts_pkg::OP_WRITE8: begin
                repeat (2) script.push_back(i2c_rts_pkg::STS_TXDATA_ACK);
            end
            i2c_rts_pkg::OP_WRITE16: begin
                repeat (4) script.push_back(i2c_rts_pkg::STS_TXDATA_ACK);
            end
            i2c_rts_pkg::OP_BURST: begin
                script.push_back(i2c_rts_pkg::STS_TXDATA_ACK);
                script.push_back(i2c_rts_pkg::STS_RSTART);
                script.push_back(i2c_rts_pkg::STS_SLAR_ACK);
                repeat (start.burst_len - 1) script.push_back(i2c_rts_pkg::STS_RXDATA_ACK);
                script.push_back(i2c_rts_pkg::STS_RXDATA_NACK);
            end
            i2c_rts_pkg::OP_READ16: begin
                repeat (2) script.push_back(i2c_rts_pkg::STS_TXDATA_ACK);
                script.push_back(i2c_rts_pkg::STS_RSTART);
                script.push_back(i2c_rts_pkg::STS_SLAR_ACK);
                script.push_back(i2c_rts_pkg::STS_RXDATA_ACK);
                script.push_back(i2c_rts_pkg::STS_RXDATA_NACK);
            end
            default: ;
        endcase
        send_request(start);
        for (n = 0; n < script.size(); n++) begin
            awaited = script[n];
            if ($urandom_range(0, 99) < noise_pct) begin
                // a begin while busy or a stray status, both dropped
                if ($urandom_range(0, 1)) begin
                    rq = random_request();
                    rq.cmd = i2c_rts_pkg::CMD_BEGIN;
                end else begin
                    rq = status_report(ignored_status(awaited), 1'b0);
                end
                send_request(rq);
            end
            if ($urandom_range(0, 99) < abort_pct) begin
                if ($urandom_range(0, 1)) begin
                    sts = 8'($urandom_range(0, 255));
                    while (sts == awaited)
                        sts = 8'($urandom_range(0, 255));
                    send_request(status_report(sts, 1'b1));
                end else begin
                    case ($urandom_range(0, 3))
                        0:       sts = i2c_rts_pkg::STS_BUS_ERR;
                        1:       sts = i2c_rts_pkg::STS_SLAW_NACK;
                        2:       sts = i2c_rts_pkg::STS_TXDATA_NACK;
                        default: sts = i2c_rts_pkg::STS_SLAR_NACK;
                    endcase
                    send_request(status_report(sts, 1'b0));
                end
                break;
            end
            // the awaited status advances even with the timeout flag up
            send_request(status_report(awaited, $urandom_range(0, 9) == 0));
        end
    endtask

    // reports while idle and begins that are refused at once
    task automatic test_idle_and_refused();
        send_request(status_report(i2c_rts_pkg::STS_START, 1'b1));
        send_request(begin_request(3'd5, 8'h00, 16'h0000, 16'h0000, 9'd0));
        send_request(begin_request(3'd7, 8'hFF, 16'hFFFF, 16'hFFFF, 9'd511));
        send_request(begin_request(i2c_rts_pkg::OP_BURST, 8'h10, 16'h0001, 16'h0000, 9'd0));
        send_request(begin_request(i2c_rts_pkg::OP_BURST, 8'h10, 16'h0001, 16'h0000,
                                   9'(i2c_rts_pkg::MAX_BURST + 1)));
        wait_until_drained();
    endtask

    // every transaction once, field extremes on the bus bytes
    task automatic test_each_operation();
        run_transaction(begin_request(i2c_rts_pkg::OP_PROBE, 8'hFF, 16'h0000, 16'h0000,
                                      9'd0), 0, 0);
        run_transaction(begin_request(i2c_rts_pkg::OP_WRITE8, 8'h00, 16'hFFFF, 16'hFFFF,
                                      9'd0), 0, 0);
        run_transaction(begin_request(i2c_rts_pkg::OP_BURST, 8'hFE, 16'h00FF, 16'h0000,
                                      9'd1), 0, 0);
        run_transaction(begin_request(i2c_rts_pkg::OP_WRITE16, 8'h80, 16'hFFFF, 16'h0000,
                                      9'd0), 0, 0);
        run_transaction(begin_request(i2c_rts_pkg::OP_READ16, 8'h7E, 16'h0000, 16'hFFFF,
                                      9'd0), 0, 0);
        wait_until_drained();
    endtask

    // begin while busy, awaited status with timeout, nack and timeout aborts
    task automatic test_busy_and_aborts();
        send_request(begin_request(i2c_rts_pkg::OP_PROBE, 8'hA0, 16'h1234, 16'h5678, 9'd3));
        send_request(begin_request(i2c_rts_pkg::OP_WRITE8, 8'h42, 16'h0011, 16'h0022, 9'd0));
        send_request(status_report(i2c_rts_pkg::STS_START, 1'b1));
        send_request(status_report(i2c_rts_pkg::STS_SLAW_ACK, 1'b1));
        send_request(begin_request(i2c_rts_pkg::OP_PROBE, 8'h50, 16'h0000, 16'h0000, 9'd0));
        send_request(status_report(i2c_rts_pkg::STS_START, 1'b0));
        send_request(status_report(i2c_rts_pkg::STS_SLAW_NACK, 1'b0));
        send_request(begin_request(i2c_rts_pkg::OP_PROBE, 8'h52, 16'h0000, 16'h0000, 9'd0));
        send_request(status_report(8'h33, 1'b1));
        wait_until_drained();
    endtask

    // the longest burst read the block accepts
    task automatic test_longest_burst();
        run_transaction(begin_request(i2c_rts_pkg::OP_BURST, 8'hC4, 16'h0080, 16'h0000,
                                      9'(i2c_rts_pkg::MAX_BURST)), 5, 0);
        wait_until_drained();
    endtask

    // random traffic, mostly complete transactions, with one full drain midway
    task automatic test_random_traffic(input int unsigned target);
        int unsigned pick;
        logic [8:0]  len;
        logic        drained;
        drained = 1'b0;
        while (requests_sent < target) begin
            if (!drained && requests_sent >= target / 2) begin
                wait_until_drained();
                drained = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                send_request(status_report(8'($urandom_range(0, 255)),
                                           1'($urandom_range(0, 1))));
            end else if (pick < 14) begin
                send_request(refused_begin());
            end else begin
                len = ($urandom_range(0, 59) == 0)
                    ? 9'($urandom_range(1, i2c_rts_pkg::MAX_BURST))
                    : 9'($urandom_range(1, 6));
                run_transaction(begin_request(3'($urandom_range(0, 4)),
                                              8'($urandom_range(0, 255)),
                                              16'($urandom_range(0, 65535)),
                                              16'($urandom_range(0, 65535)), len), 12, 4);
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_idle_and_refused();
        test_each_operation();
        test_busy_and_aborts();
        test_longest_burst();
        test_random_traffic(1600);
        wait_until_drained();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && answers_due.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // hang guard, far above the slowest legal run
    initial begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
